@@ hdl/assert_macros.svh @@
// Assertion macros used by the flick start tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clk_i edge, off while rst_ni is low.
`define TFST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication: when ante holds, cons must hold too.
`define TFST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TFST_ASSERT(lbl, prop, msg)
`define TFST_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/tfst_pkg.sv @@
// Shared constants, types and helpers of the flick start tracker.
package tfst_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned SCALE_W = 20;
  localparam int unsigned SPEED_W = 37;
  localparam int unsigned PROD_W  = DIST_W + SCALE_W;
  localparam int unsigned CNT_W   = $clog2(SPEED_W + 1);

  localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(1000000);

  // Drag direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  // Request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DRAG  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_DRAG_THR   = 2'd0;
  localparam logic [1:0] CFG_MAX_DUR    = 2'd1;
  localparam logic [1:0] CFG_SPEEDUP    = 2'd2;
  localparam logic [1:0] CFG_IGNORE_CNT = 2'd3;

  // Divider control and status
  typedef struct packed {
    logic                 start;
    logic [SPEED_W-1:0]   dividend;
    logic [TIME_W-1:0]    divisor;
  } div_ctl_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
  } div_stat_t;

  // Unsigned distance between two signed coordinates
  function automatic logic [DIST_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                 input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    abs_diff = d[POS_W] ? DIST_W'(-d) : DIST_W'(d);
  endfunction

endpackage

@@ hdl/touch_flick_start_tracker.sv @@
// Top level of the flick start tracker: sequencer, state and output register.
//
// Input channel s_axis: one item per touch event. tuser carries the request
// kind (0 start of gesture, 1 drag), tdata the coordinate and timestamp.
// Output channel m_axis: exactly one result item per input item, in order,
// with the flick start coordinate, the move time and the drag direction.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i at once.
//
// Steps: a start item goes from idle to the result step; a drag item that
// turns or adopts a new start passes the drag step first; any other drag
// item also passes the product step, the 37-step serial divider that forms
// the speed, and the speed step. s_axis_tready is high only while idle.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls, the following result waits in the
// last sequencer step until the output register is free. Reset clears all
// tracker state to a start at coordinate and time zero, loads the defaults;
// the user, not the block, sees that no item is accepted while reset is low.
module touch_flick_start_tracker import tfst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // position[15:0], timestamp[47:16]
  input  logic        s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // start_position[15:0], move_time[47:16],
                                      // drag_direction[49:48], zero fill
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DRAG = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SPD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [15:0]       drag_thr_q;
  logic [TIME_W-1:0] max_dur_q;
  logic [15:0]       speedup_inc_q;
  logic [3:0]        ignore_cnt_q;

  // Latched input item
  logic signed [POS_W-1:0] in_pos_q;
  logic [TIME_W-1:0]       in_time_q;

  // Tracker state
  logic signed [POS_W-1:0] last_pos_q, turn_pos_q, ns_pos_q, su_pos_q, ss_pos_q;
  logic [TIME_W-1:0]       last_time_q, turn_time_q, ns_time_q, su_time_q, ss_time_q;
  logic [1:0]              dir_q;
  logic                    turn_reg_q, su_reg_q;
  logic [SPEED_W-1:0]      prev_speed_q;
  logic [3:0]              ignore_left_q;

  logic [PROD_W-1:0]       prod_q;
  logic                    div_start_q;
  logic                    out_valid_q;
  logic [55:0]             out_data_q;

  div_ctl_t           div_ctl;
  div_stat_t          div_stat;
  logic [SPEED_W-1:0] quotient;

  logic s_accept;
  logic out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Drag step: direction, turn point and normal start
  logic [1:0]              nd, dir_n;
  logic                    changed, registered;
  logic signed [POS_W-1:0] turn_pos_n;
  logic [TIME_W-1:0]       turn_time_n;
  logic                    turn_reg_n;

  always_comb begin
    nd = DIR_NONE;
    if (in_pos_q > last_pos_q && dir_q != DIR_FWD) begin
      nd = DIR_FWD;
    end else if (in_pos_q < last_pos_q && dir_q != DIR_BACK) begin
      nd = DIR_BACK;
    end
    changed     = (nd != DIR_NONE) && (dir_q != DIR_NONE);
    dir_n       = (nd != DIR_NONE) ? nd : dir_q;
    turn_pos_n  = changed ? in_pos_q : turn_pos_q;
    turn_time_n = changed ? in_time_q : turn_time_q;
    turn_reg_n  = changed ? 1'b0 : turn_reg_q;
    registered  = !turn_reg_n && (turn_pos_n != ns_pos_q) && (drag_thr_q != '0) &&
                  (abs_diff(turn_pos_n, in_pos_q) > drag_thr_q);
  end

  // Speed step: speed-up detection and speed-up start
  logic [TIME_W-1:0]       dt;
  logic [SPEED_W-1:0]      speed;
  logic [3:0]              ignore_dec, ignore_n;
  logic                    su_hit, su_adopt;
  logic signed [POS_W-1:0] su_pos_n, ss_pos_n;
  logic [TIME_W-1:0]       su_time_n, ss_time_n;
  logic                    su_reg_n;

  assign dt = in_time_q - last_time_q;

  always_comb begin
    speed      = (dt != '0) ? quotient : '0;
    ignore_dec = (ignore_left_q != '0) ? ignore_left_q - 4'd1 : ignore_left_q;
    su_hit     = (ignore_dec == '0) && (prev_speed_q != '0) &&
                 ({1'b0, speed} > ({1'b0, prev_speed_q} + (SPEED_W + 1)'(speedup_inc_q))) &&
                 (((dir_q == DIR_FWD) && (in_pos_q > last_pos_q)) ||
                  ((dir_q == DIR_BACK) && (in_pos_q < last_pos_q)));
    su_pos_n  = su_hit ? last_pos_q : su_pos_q;
    su_time_n = su_hit ? last_time_q : su_time_q;
    su_reg_n  = su_hit ? 1'b0 : su_reg_q;
    ignore_n  = su_hit ? ignore_cnt_q : ignore_dec;
    ss_pos_n  = su_hit ? ns_pos_q : ss_pos_q;
    ss_time_n = su_hit ? ns_time_q : ss_time_q;
    su_adopt  = !su_reg_n && (su_pos_n != ss_pos_n) && (drag_thr_q != '0) &&
                (abs_diff(su_pos_n, in_pos_q) > drag_thr_q);
  end

  // Result selection by the maximum-duration rule
  logic [TIME_W-1:0]       normal_time, mt;
  logic signed [POS_W-1:0] sp;

  always_comb begin
    normal_time = in_time_q - ns_time_q;
    if (normal_time > max_dur_q) begin
      sp = ss_pos_q;
      mt = in_time_q - ss_time_q;
    end else begin
      sp = ns_pos_q;
      mt = normal_time;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = (s_axis_tuser == REQ_START) ? ST_OUT : ST_DRAG;
        end
      end
      ST_DRAG: state_d = (changed || registered) ? ST_OUT : ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_SPD;
        end
      end
      ST_SPD:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Divider hookup
  assign div_ctl.start    = div_start_q;
  assign div_ctl.dividend = SPEED_W'(prod_q);
  assign div_ctl.divisor  = dt;

  tfst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Product register in front of the divider
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(abs_diff(last_pos_q, in_pos_q)) * PROD_W'(SPEED_SCALE);
    end
  end

  // Input latch and output payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_pos_q  <= s_axis_tdata[15:0];
      in_time_q <= s_axis_tdata[47:16];
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= {6'd0, dir_q, mt, sp};
    end
  end

  // Sequencer, configuration and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      div_start_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      drag_thr_q    <= 16'd0;
      max_dur_q     <= TIME_W'(125000);
      speedup_inc_q <= 16'd500;
      ignore_cnt_q  <= 4'd3;
      last_pos_q    <= '0;
      last_time_q   <= '0;
      dir_q         <= DIR_NONE;
      turn_pos_q    <= '0;
      turn_time_q   <= '0;
      ns_pos_q      <= '0;
      ns_time_q     <= '0;
      su_pos_q      <= '0;
      su_time_q     <= '0;
      ss_pos_q      <= '0;
      ss_time_q     <= '0;
      turn_reg_q    <= 1'b0;
      su_reg_q      <= 1'b0;
      prev_speed_q  <= '0;
      ignore_left_q <= '0;
    end else begin
      state_q     <= state_d;
      div_start_q <= (state_q == ST_MUL);

      // output register handshake
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // register writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DRAG_THR:   drag_thr_q    <= cfg_data_i[15:0];
          CFG_MAX_DUR:    max_dur_q     <= cfg_data_i;
          CFG_SPEEDUP:    speedup_inc_q <= cfg_data_i[15:0];
          CFG_IGNORE_CNT: ignore_cnt_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end

      // start of gesture
      if (s_accept && s_axis_tuser == REQ_START) begin
        last_pos_q    <= s_axis_tdata[15:0];
        last_time_q   <= s_axis_tdata[47:16];
        dir_q         <= DIR_NONE;
        turn_pos_q    <= s_axis_tdata[15:0];
        turn_time_q   <= s_axis_tdata[47:16];
        ns_pos_q      <= s_axis_tdata[15:0];
        ns_time_q     <= s_axis_tdata[47:16];
        su_pos_q      <= s_axis_tdata[15:0];
        su_time_q     <= s_axis_tdata[47:16];
        ss_pos_q      <= s_axis_tdata[15:0];
        ss_time_q     <= s_axis_tdata[47:16];
        turn_reg_q    <= 1'b0;
        su_reg_q      <= 1'b0;
        prev_speed_q  <= '0;
        ignore_left_q <= '0;
      end

      // drag: direction and turn tracking
      if (state_q == ST_DRAG) begin
        dir_q       <= dir_n;
        turn_pos_q  <= turn_pos_n;
        turn_time_q <= turn_time_n;
        turn_reg_q  <= turn_reg_n;
        if (registered) begin
          ns_pos_q      <= turn_pos_n;
          ns_time_q     <= turn_time_n;
          turn_reg_q    <= 1'b1;
          su_pos_q      <= turn_pos_n;
          su_time_q     <= turn_time_n;
          ss_pos_q      <= turn_pos_n;
          ss_time_q     <= turn_time_n;
          su_reg_q      <= 1'b0;
          ignore_left_q <= '0;
          prev_speed_q  <= '0;
        end
        if (changed || registered) begin
          last_pos_q  <= in_pos_q;
          last_time_q <= in_time_q;
        end
      end

      // drag: speed update
      if (state_q == ST_SPD) begin
        su_pos_q      <= su_pos_n;
        su_time_q     <= su_time_n;
        ignore_left_q <= ignore_n;
        prev_speed_q  <= speed;
        last_pos_q    <= in_pos_q;
        last_time_q   <= in_time_q;
        if (su_adopt) begin
          ss_pos_q  <= su_pos_n;
          ss_time_q <= su_time_n;
          su_reg_q  <= 1'b1;
        end else begin
          ss_pos_q  <= ss_pos_n;
          ss_time_q <= ss_time_n;
          su_reg_q  <= su_reg_n;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `TFST_ASSERT(a_busy_after_accept, s_accept |=> !s_axis_tready,
               "tracker ready in the cycle after an accepted item")
  `TFST_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == ST_DIV,
                   "divider finished outside the divide step")
  `TFST_ASSERT_IMP(a_div_busy_in_div, div_stat.busy, state_q == ST_DIV,
                   "divider running outside the divide step")
  `TFST_ASSERT(a_dir_code, dir_q != 2'd3, "drag direction holds an unused code")
  `TFST_ASSERT(a_start_to_out,
               (s_accept && s_axis_tuser == REQ_START) |=> state_q == ST_OUT,
               "start item did not go straight to the result step")

endmodule

@@ hdl/tfst_div.sv @@
// Restoring serial divider: one quotient bit per cycle.
module tfst_div import tfst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_ctl_t             ctl_i,
  output div_stat_t            stat_o,
  output logic [SPEED_W-1:0]   quotient_o
);

  logic [TIME_W-1:0]  rem_q, rem_d;
  logic [SPEED_W-1:0] quo_q, quo_d;
  logic [TIME_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [TIME_W:0]    shifted;
  logic [TIME_W:0]    trial;

  // Operand load on start, else one trial subtraction of the shifted remainder
  always_comb begin
    shifted = {rem_q, quo_q[SPEED_W-1]};
    trial   = shifted - {1'b0, dsr_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (ctl_i.start) begin
      rem_d = '0;
      quo_d = ctl_i.dividend;
      dsr_d = ctl_i.divisor;
      cnt_d = CNT_W'(SPEED_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[TIME_W]) begin
        rem_d = trial[TIME_W-1:0];
        quo_d = {quo_q[SPEED_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[TIME_W-1:0];
        quo_d = {quo_q[SPEED_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ dv/touch_flick_start_tracker_chk.sv @@
// Flick start tracker checker: watches all channels, predicts each result item and compares.
`timescale 1ns / 1ps

module touch_flick_start_tracker_chk import tfst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // position[15:0], timestamp[47:16]
  input  logic        s_axis_tuser,   // req_type[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // start_position[15:0], move_time[47:16],
                                      // drag_direction[49:48], zero fill
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatch_cnt_o,
  output int          flicks_due_o
);

  // Register defaults after reset
  localparam logic [15:0] THR_DEFAULT    = 16'd0;
  localparam logic [31:0] MAX_DUR_DEFAULT = 32'd125000;
  localparam logic [15:0] SPEEDUP_DEFAULT = 16'd500;
  localparam logic [3:0]  IGNORE_DEFAULT  = 4'd3;

  localparam logic [63:0] SPEED_CEIL = (64'd1 << SPEED_W) - 64'd1;

  typedef struct packed {
    logic signed [15:0] pos;
    logic [31:0]        mt;
    logic [1:0]         dir;
  } flick_t;

  flick_t flick_due_q[$];

  // Shadow registers
  logic [15:0] thr;
  logic [31:0] max_dur;
  logic [15:0] su_inc;
  logic [3:0]  ign_cnt;

  // Tracker state
  logic signed [15:0] last_pos, turn_pos, norm_pos, su_pos, su_start_pos;
  logic [31:0]        last_t, turn_t, norm_t, su_t, su_start_t;
  logic [1:0]         dir;
  logic               turn_reg, su_reg;
  logic [36:0]        prev_speed;
  logic [3:0]         ignore_left;

  initial begin
    mismatch_cnt_o = 0;
    flicks_due_o   = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: %s got %0h, predicted %0h", $time, what, got, want);
    mismatch_cnt_o++;
  endtask

  function automatic int unsigned gap(input logic signed [15:0] a,
                                      input logic signed [15:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Zero threshold means no point is ever adopted
  function automatic bit far_apart(input logic signed [15:0] a,
                                   input logic signed [15:0] b);
    return thr != 16'd0 && gap(a, b) > thr;
  endfunction

  task automatic restart_gesture(input logic signed [15:0] pos, input logic [31:0] now);
    last_pos = pos;     last_t = now;
    dir = DIR_NONE;
    turn_pos = pos;     turn_t = now;
    norm_pos = pos;     norm_t = now;
    su_pos = pos;       su_t = now;
    su_start_pos = pos; su_start_t = now;
    turn_reg = 1'b0;
    su_reg = 1'b0;
    prev_speed = '0;
    ignore_left = '0;
  endtask

  // Speed and speed-up start bookkeeping for a plain drag step
  task automatic track_speed(input logic signed [15:0] pos, input logic [31:0] now);
    logic [31:0] dt;
    logic [63:0] spd;
    dt = now - last_t;
    spd = '0;
    if (dt != 32'd0) begin
      spd = (64'(gap(last_pos, pos)) * 64'(SPEED_SCALE)) / 64'(dt);
      if (spd > SPEED_CEIL) spd = SPEED_CEIL;
    end
    if (ignore_left != 4'd0) ignore_left--;
    if (ignore_left == 4'd0 && prev_speed != '0 &&
        spd > 64'(prev_speed) + 64'(su_inc) &&
        ((dir == DIR_FWD && pos > last_pos) || (dir == DIR_BACK && pos < last_pos))) begin
      su_pos = last_pos;
      su_t = last_t;
      su_reg = 1'b0;
      ignore_left = ign_cnt;
      su_start_pos = norm_pos;
      su_start_t = norm_t;
    end
    if (!su_reg && su_pos != su_start_pos && far_apart(su_pos, pos)) begin
      su_start_pos = su_pos;
      su_start_t = su_t;
      su_reg = 1'b1;
    end
    prev_speed = spd[36:0];
  endtask

  // Direction, turn point and normal start for a drag item
  task automatic track_drag(input logic signed [15:0] pos, input logic [31:0] now);
    logic       turned, adopted;
    logic [1:0] nd;
    turned = 1'b0;
    adopted = 1'b0;
    nd = DIR_NONE;
    if (pos > last_pos && dir != DIR_FWD) nd = DIR_FWD;
    else if (pos < last_pos && dir != DIR_BACK) nd = DIR_BACK;

    if (nd != DIR_NONE) begin
      if (dir != DIR_NONE) begin
        turn_pos = pos;
        turn_t = now;
        turn_reg = 1'b0;
        turned = 1'b1;
      end
      dir = nd;
    end

    if (!turn_reg && turn_pos != norm_pos && far_apart(turn_pos, pos)) begin
      norm_pos = turn_pos;
      norm_t = turn_t;
      turn_reg = 1'b1;
      adopted = 1'b1;
    end

    if (!turned && !adopted) begin
      track_speed(pos, now);
    end else if (adopted) begin
      su_pos = norm_pos;
      su_t = norm_t;
      su_start_pos = norm_pos;
      su_start_t = norm_t;
      su_reg = 1'b0;
      ignore_left = '0;
      prev_speed = '0;
    end

    last_pos = pos;
    last_t = now;
  endtask

  // Update state for one touch item and queue the flick start it yields
  task automatic track_touch(input logic kind, input logic signed [15:0] pos,
                             input logic [31:0] now);
    flick_t      res;
    logic [31:0] normal_mt;
    if (kind == REQ_START) restart_gesture(pos, now);
    else track_drag(pos, now);

    normal_mt = now - norm_t;
    if (normal_mt > max_dur) begin
      res.pos = su_start_pos;
      res.mt  = now - su_start_t;
    end else begin
      res.pos = norm_pos;
      res.mt  = normal_mt;
    end
    res.dir = dir;
    flick_due_q.push_back(res);
  endtask

  always @(posedge clk_i) begin
    flick_t got, want;
    if (!rst_ni) begin
      thr = THR_DEFAULT;
      max_dur = MAX_DUR_DEFAULT;
      su_inc = SPEEDUP_DEFAULT;
      ign_cnt = IGNORE_DEFAULT;
      restart_gesture('0, '0);
      flick_due_q.delete();
      flicks_due_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DRAG_THR:   thr = cfg_data_i[15:0];
          CFG_MAX_DUR:    max_dur = cfg_data_i;
          CFG_SPEEDUP:    su_inc = cfg_data_i[15:0];
          CFG_IGNORE_CNT: ign_cnt = cfg_data_i[3:0];
          default: ;
        endcase
      end

      // result side
      if (m_axis_tvalid && m_axis_tready) begin
        got.pos = m_axis_tdata[15:0];
        got.mt  = m_axis_tdata[47:16];
        got.dir = m_axis_tdata[49:48];
        if (flick_due_q.size() == 0) begin
          flag_mismatch("result item with nothing pending", 32'(got.mt), '0);
        end else begin
          want = flick_due_q.pop_front();
          if (got.pos !== want.pos)
            flag_mismatch("start_position", 32'(got.pos), 32'(want.pos));
          if (got.mt !== want.mt)
            flag_mismatch("move_time", got.mt, want.mt);
          if (got.dir !== want.dir)
            flag_mismatch("drag_direction", 32'(got.dir), 32'(want.dir));
        end
      end

      // touch side
      if (s_axis_tvalid && s_axis_tready)
        track_touch(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]);

      flicks_due_o <= flick_due_q.size();
    end
  end

endmodule

@@ dv/touch_flick_start_tracker_tb.sv @@
// Flick start tracker testbench top: clock, reset, touch stimulus, receiver and verdict.
`timescale 1ns / 1ps

module touch_flick_start_tracker_tb import tfst_pkg::*;;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 182;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // position[15:0], timestamp[47:16]
  logic        s_axis_tuser = 1'b0; // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // start_position[15:0], move_time[47:16],
                                    // drag_direction[49:48], zero fill
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_DRAG_THR;
  logic [31:0] cfg_data_i = '0;

  int mismatch_cnt;
  int flicks_due;
  int send_idle_pct = 23;
  int recv_idle_pct = 84;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  touch_flick_start_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  touch_flick_start_tracker_chk u_chk (
    .*,
    .mismatch_cnt_o (mismatch_cnt),
    .flicks_due_o   (flicks_due)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one touch item and wait until it is taken
  task automatic send_touch(input logic kind, input logic [15:0] pos, input logic [31:0] ts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ts, pos};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (flicks_due != 0);
  endtask

  task automatic set_tuning(input logic [15:0] thr, input logic [31:0] dur,
                            input logic [15:0] su, input logic [3:0] ign);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DRAG_THR;
    cfg_data_i <= 32'(thr);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_DUR;
    cfg_data_i <= dur;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPEEDUP;
    cfg_data_i <= 32'(su);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IGNORE_CNT;
    cfg_data_i <= 32'(ign);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One gesture: a start then n drags with turns, jumps and uneven timing
  task automatic run_gesture(input int n);
    int          p, dirn, step;
    logic [31:0] t, dt;
    p = $signed(16'($urandom));
    t = $urandom;
    dirn = $urandom_range(0, 1) ? 1 : -1;
    send_touch(REQ_START, 16'(p), t);
    repeat (n) begin
      if ($urandom_range(0, 99) < 20) dirn = -dirn;
      case ($urandom_range(0, 9))
        0:       step = 0;
        1:       step = $urandom_range(100, 3000);
        default: step = $urandom_range(1, 40);
      endcase
      p = p + dirn * step;
      case ($urandom_range(0, 15))
        0:       dt = '0;
        1:       dt = $urandom_range(20000, 200000);
        2:       dt = $urandom;
        default: dt = $urandom_range(50, 3000);
      endcase
      t = t + dt;
      send_touch(REQ_DRAG, 16'(p), t);
    end
  endtask

  initial begin
    int sent, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: drags before any start, extremes, wrap and zero elapsed time
    send_touch(REQ_DRAG, 16'h7fff, 32'd100);
    send_touch(REQ_DRAG, 16'h8000, 32'd100);
    send_touch(REQ_START, 16'h8000, 32'hffff_fff0);
    send_touch(REQ_DRAG, 16'(-32700), 32'h0000_0010);
    drain_results();
    set_tuning(16'd10, 32'd3000, 16'd50, 4'd2);

    // Directed: speed-up, turn adoption, max duration switch
    send_touch(REQ_START, 16'd0, 32'd1000);
    send_touch(REQ_DRAG, 16'd5, 32'd1100);
    send_touch(REQ_DRAG, 16'd30, 32'd1200);
    send_touch(REQ_DRAG, 16'd60, 32'd1250);
    send_touch(REQ_DRAG, 16'd40, 32'd1300);
    send_touch(REQ_DRAG, 16'd20, 32'd1400);
    send_touch(REQ_DRAG, 16'd0, 32'd1500);
    send_touch(REQ_DRAG, 16'(-100), 32'd1520);
    send_touch(REQ_DRAG, 16'(-200), 32'd1540);
    send_touch(REQ_DRAG, 16'(-300), 32'd1560);
    send_touch(REQ_DRAG, 16'(-300), 32'd1560);
    send_touch(REQ_DRAG, 16'(-250), 32'd9000);
    send_touch(REQ_DRAG, 16'(-200), 32'd9100);
    send_touch(REQ_DRAG, 16'h7fff, 32'd9200);
    send_touch(REQ_START, 16'h7fff, 32'hffff_ffff);
    send_touch(REQ_DRAG, 16'h8000, 32'd0);
    send_touch(REQ_DRAG, 16'h8000, 32'd0);

    // Random phases, each with its own register setting and one of three idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0, 1: begin send_idle_pct = 23; recv_idle_pct = 84; end
        2, 3: begin send_idle_pct = 84; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: set_tuning(16'd5, 32'd2000, 16'd100, 4'd3);
        1: set_tuning(16'hffff, 32'd0, 16'd0, 4'd0);
        2: set_tuning(16'd1, 32'hffff_ffff, 16'hffff, 4'hf);
        3: set_tuning(16'd0, 32'd125000, 16'd500, 4'd3);
        4: set_tuning(16'd20, 32'd50000, 16'd10, 4'd1);
        default: set_tuning(16'($urandom_range(0, 64)), $urandom,
                            16'($urandom), 4'($urandom_range(0, 15)));
      endcase
      // long receiver hold-off while items keep coming
      if (ph == 4) hold_trigger++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_touch(1'($urandom), 16'($urandom), $urandom);
          sent++;
        end else begin
          n = $urandom_range(2, 25);
          run_gesture(n);
          sent += n + 1;
        end
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tfst_pkg.sv
hdl/tfst_div.sv
hdl/touch_flick_start_tracker.sv
dv/touch_flick_start_tracker_chk.sv
dv/touch_flick_start_tracker_tb.sv
